### rtl/amt_pkg.sv
// Package for the box transform block: payload structs, widths, fixed-point constants.
// Used by every module in rtl/.
package amt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 64;
    localparam int ACC_W     = 68;
    localparam int QDIV_W    = 64;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } box_in_t;

    typedef struct packed {
        logic signed [31:0] out_min_x;
        logic signed [31:0] out_min_y;
        logic signed [31:0] out_min_z;
        logic signed [31:0] out_max_x;
        logic signed [31:0] out_max_y;
        logic signed [31:0] out_max_z;
        logic               range_fault;
    } box_out_t;

    typedef logic signed [31:0] q_t;
    typedef q_t [3:0][3:0] mat_t;

    // Round a 2*FRAC product sum to FRAC bits (ties up) and saturate.
    function automatic logic [32:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] sh;
        logic [32:0] res;
        r  = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
        sh = r >>> FRAC_BITS;
        if (sh > ACC_W'(Q_MAX))
            res = {1'b1, Q_MAX};
        else if (sh < ACC_W'(Q_MIN))
            res = {1'b1, Q_MIN};
        else
            res = {1'b0, sh[31:0]};
        return res;
    endfunction

endpackage

### rtl/amt_divider.sv
// Pipelined restoring signed divider: (v << FRAC_BITS) / w, truncated, saturated to 32 bits.
// Depends on amt_pkg. One quotient bit per stage, QDIV_W stages plus sign fix.
module amt_divider
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [31:0]     v,
    input  logic signed [31:0]     w,
    output logic                   out_valid,
    output logic signed [31:0]     q,
    output logic                   q_fault
);
    localparam int N  = amt_pkg::QDIV_W;
    localparam int NS = N + 1;

    logic [NS-1:0]         vld_reg;
    logic [NS-1:0][N-1:0]  num_reg;
    logic [NS-1:0][N-1:0]  rem_reg;
    logic [NS-1:0][32:0]   den_reg;
    logic [NS-1:0]         neg_reg;
    logic [NS-1:0]         wz_reg;
    logic [NS-1:0][1:0]    vs_reg;

    logic signed [N-1:0] num_s;
    logic [N-1:0]        num_abs;
    logic [32:0]         den_abs;

    always_comb
    begin
        num_s   = N'(v) <<< amt_pkg::FRAC_BITS;
        num_abs = num_s[N-1] ? N'(-num_s) : N'(num_s);
        den_abs = w[31] ? 33'(-{w[31], w}) : {1'b0, w};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= num_abs;
            rem_reg[0] <= '0;
            den_reg[0] <= den_abs;
            neg_reg[0] <= v[31] ^ w[31];
            wz_reg[0]  <= (w == '0);
            vs_reg[0]  <= {v[31], v != '0};
            for (int i = 1; i < NS; i++)
            begin
                logic [N:0] t;
                t = {rem_reg[i-1], num_reg[i-1][N-1]};
                if (t >= (N+1)'(den_reg[i-1]))
                begin
                    rem_reg[i] <= N'(t - (N+1)'(den_reg[i-1]));
                    num_reg[i] <= {num_reg[i-1][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= N'(t);
                    num_reg[i] <= {num_reg[i-1][N-2:0], 1'b0};
                end
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                wz_reg[i]  <= wz_reg[i-1];
                vs_reg[i]  <= vs_reg[i-1];
            end
        end
    end

    logic [N-1:0]        mag;
    logic                big;
    always_comb
    begin
        mag = num_reg[NS-1];
        q_fault = 1'b0;
        q = '0;
        big = |mag[N-1:31];
        if (wz_reg[NS-1])
        begin
            q_fault = 1'b1;
            if (vs_reg[NS-1] == 2'b01)
                q = amt_pkg::Q_MAX;
            else if (vs_reg[NS-1] == 2'b11)
                q = amt_pkg::Q_MIN;
        end
        else if (!neg_reg[NS-1])
        begin
            q_fault = big;
            q = big ? amt_pkg::Q_MAX : mag[31:0];
        end
        else
        begin
            if (big && !(mag[31:0] == 32'h8000_0000 && ~|mag[N-1:32]))
            begin
                q_fault = 1'b1;
                q = amt_pkg::Q_MIN;
            end
            else if (mag[31:0] == 32'h8000_0000 && ~|mag[N-1:32])
                q = amt_pkg::Q_MIN;
            else
                q = -$signed(mag[31:0]);
        end
    end

    assign out_valid = vld_reg[NS-1];
endmodule

### rtl/amt_corner_xform.sv
// Corner transform pipeline: multiply stage, sum stage, round, then three-lane divide.
// Depends on amt_pkg and amt_divider.
module amt_corner_xform
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic                in_first,
    input  logic                in_last,
    input  amt_pkg::q_t [2:0]   p,
    input  amt_pkg::mat_t       mat,
    output logic                out_valid,
    output logic                out_first,
    output logic                out_last,
    output amt_pkg::q_t [2:0]   t,
    output logic                t_fault
);
    localparam int AW = amt_pkg::ACC_W;
    localparam int DLY = amt_pkg::QDIV_W + 1;

    logic                          s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [1:0]                    s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic signed [3:0][3:0][63:0]  prod_reg;
    logic signed [3:0][AW-1:0]     acc_reg;
    amt_pkg::q_t [3:0]             col_reg;
    logic                          s3_flt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 3; r++)
                    prod_reg[c][r] <= 64'(p[r]) * 64'(mat[r][c]);
                prod_reg[c][3] <= 64'(mat[3][c]) <<< amt_pkg::FRAC_BITS;
            end
            s1_tag_reg <= {in_first, in_last};
            for (int c = 0; c < 4; c++)
                acc_reg[c] <= AW'($signed(prod_reg[c][0])) + AW'($signed(prod_reg[c][1]))
                            + AW'($signed(prod_reg[c][2])) + AW'($signed(prod_reg[c][3]));
            s2_tag_reg <= s1_tag_reg;
            begin
                logic f;
                logic [32:0] rs;
                f = 1'b0;
                for (int c = 0; c < 4; c++)
                begin
                    rs = amt_pkg::round_sat(acc_reg[c]);
                    col_reg[c] <= rs[31:0];
                    f = f | rs[32];
                end
                s3_flt_reg <= f;
            end
            s3_tag_reg <= s2_tag_reg;
        end
    end

    logic [DLY-1:0][2:0] tag_dly_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            tag_dly_reg <= {tag_dly_reg[DLY-2:0], {s3_flt_reg, s3_tag_reg}};
    end

    logic [2:0] dv;
    logic [2:0] df;
    for (genvar a = 0; a < 3; a++)
    begin : g_div
        amt_divider u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (s3_vld_reg),
            .v        (col_reg[a]),
            .w        (col_reg[3]),
            .out_valid(dv[a]),
            .q        (t[a]),
            .q_fault  (df[a])
        );
    end

    assign out_valid = dv[0];
    assign out_first = tag_dly_reg[DLY-1][1];
    assign out_last  = tag_dly_reg[DLY-1][0];
    assign t_fault   = tag_dly_reg[DLY-1][2] | (|df);
endmodule

### rtl/aabb_matrix_transform.sv
// Top level: box transform by a 4x4 matrix; config registers, corner sequencer, min/max.
// Depends on amt_pkg and amt_corner_xform.
//
//  port group   dir   handshake
//  box_in       in    in_valid / in_ready
//  box_out      out   out_valid / out_ready
//  cfg          in    cfg_we, cfg_idx, cfg_data
//
// Each box is sent as eight corners; one corner enters the shared transform pipeline
// per cycle unless the output is stalled. Most of the pipeline depth lies in the
// bit-per-stage dividers.
// Reset clears the matrix and all valid bits. A stalled output freezes the whole pipeline.
module aabb_matrix_transform
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  amt_pkg::box_in_t              box_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output amt_pkg::box_out_t             box_out,
    input  logic                          cfg_we,
    input  logic [amt_pkg::IDX_W-1:0]     cfg_idx,
    input  logic [amt_pkg::CFG_W-1:0]     cfg_data
);
    logic [amt_pkg::NUM_REGS-1:0][amt_pkg::CFG_W-1:0] mat_reg;
    amt_pkg::mat_t mat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_reg <= '0;
        else if (cfg_we)
            mat_reg[cfg_idx] <= cfg_data;
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mat[r][0] = mat_reg[2*r][31:0];
            mat[r][1] = mat_reg[2*r][63:32];
            mat[r][2] = mat_reg[2*r+1][31:0];
            mat[r][3] = mat_reg[2*r+1][63:32];
        end
    end

    logic en;
    assign en = !out_valid || out_ready;

    logic              busy_reg;
    logic [2:0]        k_reg;
    amt_pkg::box_in_t  box_reg;

    assign in_ready = en && (!busy_reg || k_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (en)
        begin
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg    <= k_reg + 3'd1;
                busy_reg <= (k_reg != 3'd7);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            box_reg <= box_in;
    end

    amt_pkg::q_t [2:0] p;
    always_comb
    begin
        p[0] = k_reg[0] ? box_reg.box_max_x : box_reg.box_min_x;
        p[1] = k_reg[1] ? box_reg.box_max_y : box_reg.box_min_y;
        p[2] = k_reg[2] ? box_reg.box_max_z : box_reg.box_min_z;
    end

    logic              cv, cfirst, clast, cflt;
    amt_pkg::q_t [2:0] ct;

    amt_corner_xform u_xform
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (busy_reg),
        .in_first (k_reg == 3'd0),
        .in_last  (k_reg == 3'd7),
        .p        (p),
        .mat      (mat),
        .out_valid(cv),
        .out_first(cfirst),
        .out_last (clast),
        .t        (ct),
        .t_fault  (cflt)
    );

    amt_pkg::q_t [2:0] mn_reg, mx_reg;
    logic              flt_reg;
    amt_pkg::q_t [2:0] mn_next, mx_next;
    logic              flt_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mn_next[a] = (cfirst || ct[a] < mn_reg[a]) ? ct[a] : mn_reg[a];
            mx_next[a] = (cfirst || ct[a] > mx_reg[a]) ? ct[a] : mx_reg[a];
        end
        flt_next = cflt | (!cfirst & flt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en && cv)
        begin
            mn_reg  <= mn_next;
            mx_reg  <= mx_next;
            flt_reg <= flt_next;
        end
        if (en && cv && clast)
        begin
            box_out.out_min_x   <= mn_next[0];
            box_out.out_min_y   <= mn_next[1];
            box_out.out_min_z   <= mn_next[2];
            box_out.out_max_x   <= mx_next[0];
            box_out.out_max_y   <= mx_next[1];
            box_out.out_max_z   <= mx_next[2];
            box_out.range_fault <= flt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= cv && clast;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && k_reg != 3'd7) |-> !in_ready)
        else $error("input taken mid-box");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(k_reg) && $stable(busy_reg))
        else $error("sequencer moved during stall");
    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> busy_reg && k_reg == 3'd0)
        else $error("sequencer did not start");
endmodule
